[rtl/core/order_book_side_engine_defines.svh]
// Assertion macros shared by the order book side engine RTL.
`ifndef ORDER_BOOK_SIDE_ENGINE_DEFINES_SVH
`define ORDER_BOOK_SIDE_ENGINE_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define OBSE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, checked out of reset.
`define OBSE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define OBSE_ASSERT_IMP(lbl, ante, cons)
`define OBSE_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[rtl/core/obse_pkg.sv]
// Shared types, codes and defaults of the order book side engine.
`timescale 1ns / 1ps
`default_nettype none
package obse_pkg;

  localparam int unsigned LEVELS_DEF = 1024;
  localparam int unsigned POOL_DEF   = 64;
  localparam int unsigned PTR_W      = 7;
  localparam logic [PTR_W-1:0] PTR_NIL = 7'd127;
  localparam int unsigned LI_MAX_W   = 16;
  localparam int unsigned SUM_W      = 38;

  // Operation codes
  localparam logic [2:0] MODE_ADD    = 3'd0;
  localparam logic [2:0] MODE_CANCEL = 3'd1;
  localparam logic [2:0] MODE_FILL   = 3'd2;
  localparam logic [2:0] MODE_LIST   = 3'd4;

  // Result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_OUT_WIN   = 3'd2;
  localparam logic [2:0] ST_POOL_FULL = 3'd3;
  localparam logic [2:0] ST_OVERFILL  = 3'd4;

  // Configuration register indexes
  localparam logic [7:0] CFG_BASE_PRICE = 8'd0;
  localparam logic [7:0] CFG_BEST_HIGH  = 8'd1;

  // Classified command handed from front to back
  typedef struct packed {
    logic [2:0]          mode;
    logic                win;
    logic [LI_MAX_W-1:0] li;
    logic [63:0]         id;
    logic [31:0]         qty;
    logic [63:0]         seq;
  } cmd_t;

  // One price level record
  typedef struct packed {
    logic [PTR_W-1:0] head;
    logic [PTR_W-1:0] tail;
    logic [SUM_W-1:0] sum;
  } level_t;

endpackage
`default_nettype wire

[rtl/core/obse_ram.sv]
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module obse_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry, read one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[rtl/core/obse_front.sv]
// Front end: window check of incoming commands and a two-entry command queue.
`timescale 1ns / 1ps
`default_nettype none
module obse_front #(
  parameter int unsigned LEVELS = obse_pkg::LEVELS_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [2:0]   mode_i,
  input  wire logic [31:0]  price_i,
  input  wire logic [63:0]  order_id_i,
  input  wire logic [31:0]  quantity_i,
  input  wire logic [63:0]  sequence_req_i,
  input  wire logic [31:0]  base_price_i,
  output logic              full_o,
  output logic              valid_o,
  output obse_pkg::cmd_t    head_o,
  input  wire logic         pop_i
);

  obse_pkg::cmd_t cmd_in;
  obse_pkg::cmd_t q_q [2];
  logic           wptr_q, rptr_q;
  logic [1:0]     cnt_q;
  logic [31:0]    offset;

  // Classify: offset from the window base and window membership
  always_comb begin
    offset      = price_i - base_price_i;
    cmd_in.mode = mode_i;
    cmd_in.win  = (price_i >= base_price_i) && (offset < LEVELS);
    cmd_in.li   = offset[obse_pkg::LI_MAX_W-1:0];
    cmd_in.id   = order_id_i;
    cmd_in.qty  = quantity_i;
    cmd_in.seq  = sequence_req_i;
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      q_q[wptr_q] <= cmd_in;
    end
  end

  // Queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = q_q[rptr_q];

endmodule
`default_nettype wire

[rtl/core/obse_back.sv]
// Back end: sequencer that runs commands against level, node and occupancy memories.
`timescale 1ns / 1ps
`default_nettype none
module obse_back #(
  parameter int unsigned LEVELS     = obse_pkg::LEVELS_DEF,
  parameter int unsigned POOL_NODES = obse_pkg::POOL_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cmd_valid_i,
  input  obse_pkg::cmd_t    cmd_i,
  output logic              cmd_pop_o,
  input  wire logic [31:0]  base_price_i,
  input  wire logic         best_high_i,
  output logic              clearing_o,
  output logic              strobe_o,
  output logic [2:0]        status_o,
  output logic              best_valid_o,
  output logic [31:0]       best_level_price_o,
  output logic [37:0]       level_total_o,
  output logic              level_occupied_o,
  output logic [63:0]       maker_id_o,
  output logic [31:0]       maker_qty_o,
  output logic [63:0]       maker_seq_o,
  output logic              last_o
);

  localparam int unsigned LIW       = $clog2(LEVELS);
  localparam int unsigned OCC_WORDS = (LEVELS + 63) / 64;
  localparam int unsigned OW        = (OCC_WORDS > 1) ? $clog2(OCC_WORDS) : 1;
  localparam int unsigned PW        = $clog2(POOL_NODES);
  localparam int unsigned CW        = $clog2(POOL_NODES + 1);
  localparam int unsigned PTRW      = obse_pkg::PTR_W;
  localparam int unsigned SW        = obse_pkg::SUM_W;
  localparam logic [PTRW-1:0] NPTR  = PTRW'(POOL_NODES);
  localparam logic [PTRW-1:0] NIL   = obse_pkg::PTR_NIL;

  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_LRD    = 5'd2;
  localparam logic [4:0] S_LCAP   = 5'd3;
  localparam logic [4:0] S_ADD2   = 5'd4;
  localparam logic [4:0] S_FIND   = 5'd5;
  localparam logic [4:0] S_FCHK   = 5'd6;
  localparam logic [4:0] S_UNL    = 5'd7;
  localparam logic [4:0] S_FILL   = 5'd8;
  localparam logic [4:0] S_SRD    = 5'd9;
  localparam logic [4:0] S_SCHK   = 5'd10;
  localparam logic [4:0] S_COMMIT = 5'd11;
  localparam logic [4:0] S_OCC    = 5'd12;
  localparam logic [4:0] S_BST0   = 5'd13;
  localparam logic [4:0] S_BSCAN  = 5'd14;
  localparam logic [4:0] S_OUT    = 5'd15;
  localparam logic [4:0] S_LSTR   = 5'd16;
  localparam logic [4:0] S_LSTO   = 5'd17;

  // Control state
  logic [4:0]            state_q, state_d;
  logic [LIW-1:0]        clr_q, clr_d;
  logic [POOL_NODES-1:0] free_q, free_d;
  logic [CW-1:0]         fcnt_q, fcnt_d;
  logic                  strobe_q, strobe_d;

  // Command and working registers
  logic [2:0]      mode_q, mode_d;
  logic            win_q, win_d;
  logic [LIW-1:0]  li_q, li_d;
  logic [63:0]     id_q, id_d;
  logic [31:0]     qty_q, qty_d;
  logic [63:0]     seq_q, seq_d;
  logic [PTRW-1:0] head_q, head_d, tail_q, tail_d;
  logic [SW-1:0]   sum_q, sum_d;
  logic [PTRW-1:0] cur_q, cur_d, nn_q, nn_d, np_q, np_d, nx_q, nx_d;
  logic [31:0]     nq_q, nq_d;
  logic [CW-1:0]   steps_q, steps_d, cnt_q, cnt_d;
  logic [2:0]      status_q, status_d;
  logic            sweep_q, sweep_d;
  logic [OW-1:0]   bw_q, bw_d;
  logic            bv_q, bv_d;
  logic [31:0]     bp_q, bp_d;

  // Result registers
  logic [2:0]  ostat_q, ostat_d;
  logic        obv_q, obv_d;
  logic [31:0] obp_q, obp_d;
  logic [37:0] otot_q, otot_d;
  logic        oocc_q, oocc_d;
  logic [63:0] oid_q, oid_d;
  logic [31:0] oqty_q, oqty_d;
  logic [63:0] oseq_q, oseq_d;
  logic        olast_q, olast_d;

  // Memory ports
  logic                 lv_we;
  logic [LIW-1:0]       lv_waddr;
  obse_pkg::level_t     lv_wdata, lv_rdata;
  logic                 oc_we;
  logic [OW-1:0]        oc_waddr, oc_raddr;
  logic [63:0]          oc_wdata, oc_rdata;
  logic [PW-1:0]        n_raddr, nw_addr;
  logic                 nid_we, nqty_we, nseq_we, nnext_we, nprev_we;
  logic [31:0]          nqty_wdata;
  logic [PW-1:0]        nnext_waddr, nprev_waddr;
  logic [PTRW-1:0]      nnext_wdata, nprev_wdata;
  logic [63:0]          nid_rd, nseq_rd;
  logic [31:0]          nqty_rd;
  logic [PTRW-1:0]      nnext_rd, nprev_rd;

  // Helpers
  logic [PW-1:0]   alloc;
  logic [5:0]      bit_hit;
  logic [OW-1:0]   bw_start, bw_end, bw_next, li_word;
  logic            occ_now;
  logic [31:0]     amt;
  logic            lst_last;

  // Lowest free node
  always_comb begin
    alloc = '0;
    for (int i = POOL_NODES - 1; i >= 0; i--) begin
      if (free_q[i]) alloc = PW'(i);
    end
  end

  // Best bit inside the current occupancy word
  always_comb begin
    bit_hit = '0;
    if (best_high_i) begin
      for (int b = 0; b < 64; b++) begin
        if (oc_rdata[b]) bit_hit = 6'(b);
      end
    end else begin
      for (int b = 63; b >= 0; b--) begin
        if (oc_rdata[b]) bit_hit = 6'(b);
      end
    end
  end

  assign bw_start = best_high_i ? OW'(OCC_WORDS - 1) : '0;
  assign bw_end   = best_high_i ? '0 : OW'(OCC_WORDS - 1);
  assign bw_next  = best_high_i ? (bw_q - 1'b1) : (bw_q + 1'b1);
  assign li_word  = OW'(li_q >> 6);
  assign occ_now  = win_q && (head_q < NPTR);
  assign n_raddr  = cur_q[PW-1:0];
  assign lst_last = (nnext_rd >= NPTR) || (cnt_q == CW'(POOL_NODES - 1));
  assign amt      = (qty_q > nq_q) ? nq_q : qty_q;

  // Sequencer
  always_comb begin
    state_d = state_q;  clr_d = clr_q;  free_d = free_q;  fcnt_d = fcnt_q;
    strobe_d = 1'b0;
    mode_d = mode_q;  win_d = win_q;  li_d = li_q;  id_d = id_q;
    qty_d = qty_q;  seq_d = seq_q;  head_d = head_q;  tail_d = tail_q;
    sum_d = sum_q;  cur_d = cur_q;  nn_d = nn_q;  np_d = np_q;  nx_d = nx_q;
    nq_d = nq_q;  steps_d = steps_q;  cnt_d = cnt_q;  status_d = status_q;
    sweep_d = sweep_q;  bw_d = bw_q;  bv_d = bv_q;  bp_d = bp_q;
    ostat_d = ostat_q;  obv_d = obv_q;  obp_d = obp_q;  otot_d = otot_q;
    oocc_d = oocc_q;  oid_d = oid_q;  oqty_d = oqty_q;  oseq_d = oseq_q;
    olast_d = olast_q;
    cmd_pop_o = 1'b0;
    lv_we = 1'b0;  lv_waddr = li_q;
    lv_wdata.head = head_q;  lv_wdata.tail = tail_q;  lv_wdata.sum = sum_q;
    oc_we = 1'b0;  oc_waddr = li_word;  oc_wdata = oc_rdata;  oc_raddr = li_word;
    nw_addr = alloc;
    nid_we = 1'b0;  nqty_we = 1'b0;  nseq_we = 1'b0;  nqty_wdata = qty_q;
    nnext_we = 1'b0;  nnext_waddr = alloc;  nnext_wdata = NIL;
    nprev_we = 1'b0;  nprev_waddr = alloc;  nprev_wdata = tail_q;

    case (state_q)
      // Sweep every level to empty after reset
      S_CLR: begin
        lv_we = 1'b1;
        lv_waddr = clr_q;
        lv_wdata.head = NIL;  lv_wdata.tail = NIL;  lv_wdata.sum = '0;
        oc_we = (32'(clr_q) < OCC_WORDS);
        oc_waddr = OW'(clr_q);
        oc_wdata = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == LIW'(LEVELS - 1)) state_d = S_IDLE;
      end
      // Take the next queued command
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          mode_d = cmd_i.mode;  win_d = cmd_i.win;  li_d = cmd_i.li[LIW-1:0];
          id_d = cmd_i.id;  qty_d = cmd_i.qty;  seq_d = cmd_i.seq;
          status_d = cmd_i.win ? obse_pkg::ST_OK : obse_pkg::ST_OUT_WIN;
          state_d = cmd_i.win ? S_LRD : S_BST0;
        end
      end
      S_LRD: state_d = S_LCAP;
      // Load the level and dispatch by operation
      S_LCAP: begin
        head_d = lv_rdata.head;  tail_d = lv_rdata.tail;  sum_d = lv_rdata.sum;
        case (mode_q)
          obse_pkg::MODE_ADD: begin
            if (fcnt_q == '0) begin
              status_d = obse_pkg::ST_POOL_FULL;
              state_d = S_BST0;
            end else begin
              nid_we = 1'b1;  nqty_we = 1'b1;  nseq_we = 1'b1;
              nnext_we = 1'b1;  nprev_we = 1'b1;  nprev_wdata = lv_rdata.tail;
              free_d[alloc] = 1'b0;
              fcnt_d = fcnt_q - 1'b1;
              nn_d = PTRW'(alloc);
              tail_d = PTRW'(alloc);
              sum_d = lv_rdata.sum + SW'(qty_q);
              if (lv_rdata.head >= NPTR) begin
                head_d = PTRW'(alloc);
                state_d = S_COMMIT;
              end else begin
                cur_d = lv_rdata.tail;
                state_d = S_ADD2;
              end
            end
          end
          obse_pkg::MODE_CANCEL, obse_pkg::MODE_FILL: begin
            cur_d = lv_rdata.head;
            steps_d = '0;
            state_d = S_FIND;
          end
          default: state_d = S_BST0;
        endcase
      end
      // Link the old tail to the new node
      S_ADD2: begin
        nnext_we = 1'b1;  nnext_waddr = cur_q[PW-1:0];  nnext_wdata = nn_q;
        state_d = S_COMMIT;
      end
      // Walk the level for the oldest matching id
      S_FIND: begin
        if (cur_q >= NPTR || steps_q == CW'(POOL_NODES)) begin
          status_d = obse_pkg::ST_NOT_FOUND;
          state_d = S_BST0;
        end else begin
          state_d = S_FCHK;
        end
      end
      S_FCHK: begin
        if (nid_rd == id_q) begin
          nn_d = cur_q;  np_d = nprev_rd;  nx_d = nnext_rd;  nq_d = nqty_rd;
          sweep_d = 1'b0;
          state_d = (mode_q == obse_pkg::MODE_FILL) ? S_FILL : S_UNL;
        end else begin
          cur_d = nnext_rd;
          steps_d = steps_q + 1'b1;
          state_d = S_FIND;
        end
      end
      // Unlink one node and free it
      S_UNL: begin
        if (np_q < NPTR) begin
          nnext_we = 1'b1;  nnext_waddr = np_q[PW-1:0];  nnext_wdata = nx_q;
        end else begin
          head_d = nx_q;
        end
        if (nx_q < NPTR) begin
          nprev_we = 1'b1;  nprev_waddr = nx_q[PW-1:0];  nprev_wdata = np_q;
        end else begin
          tail_d = np_q;
        end
        sum_d = sum_q - SW'(nq_q);
        free_d[nn_q[PW-1:0]] = 1'b1;
        fcnt_d = fcnt_q + 1'b1;
        state_d = sweep_q ? S_SRD : S_COMMIT;
      end
      // Apply the fill, clamped to what rests
      S_FILL: begin
        if (qty_q > nq_q) status_d = obse_pkg::ST_OVERFILL;
        nqty_we = 1'b1;  nw_addr = nn_q[PW-1:0];  nqty_wdata = nq_q - amt;
        sum_d = sum_q - SW'(amt);
        cur_d = head_q;
        steps_d = '0;
        sweep_d = 1'b1;
        state_d = S_SRD;
      end
      // Drop every zero-quantity order of the level
      S_SRD: begin
        if (cur_q >= NPTR || steps_q == CW'(POOL_NODES)) state_d = S_COMMIT;
        else state_d = S_SCHK;
      end
      S_SCHK: begin
        cur_d = nnext_rd;
        steps_d = steps_q + 1'b1;
        if (nqty_rd == '0) begin
          nn_d = cur_q;  np_d = nprev_rd;  nx_d = nnext_rd;  nq_d = '0;
          state_d = S_UNL;
        end else begin
          state_d = S_SRD;
        end
      end
      // Write back the level and fetch its occupancy word
      S_COMMIT: begin
        lv_we = 1'b1;
        state_d = S_OCC;
      end
      S_OCC: begin
        oc_we = 1'b1;
        oc_wdata[li_q[5:0]] = (head_q < NPTR);
        state_d = S_BST0;
      end
      // Scan occupancy words from the best end
      S_BST0: begin
        oc_raddr = bw_start;
        bw_d = bw_start;
        state_d = S_BSCAN;
      end
      S_BSCAN: begin
        if (oc_rdata != '0) begin
          bv_d = 1'b1;
          bp_d = base_price_i + 32'({bw_q, bit_hit});
          state_d = S_OUT;
        end else if (bw_q == bw_end) begin
          bv_d = 1'b0;
          bp_d = '0;
          state_d = S_OUT;
        end else begin
          oc_raddr = bw_next;
          bw_d = bw_next;
        end
      end
      // Emit one result, or start the level listing
      S_OUT: begin
        ostat_d = status_q;  obv_d = bv_q;  obp_d = bp_q;
        otot_d = occ_now ? sum_q : '0;
        oocc_d = occ_now;
        if (mode_q == obse_pkg::MODE_LIST && occ_now) begin
          cur_d = head_q;
          cnt_d = '0;
          state_d = S_LSTR;
        end else begin
          strobe_d = 1'b1;
          oid_d = '0;  oqty_d = '0;  oseq_d = '0;  olast_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_LSTR: state_d = S_LSTO;
      S_LSTO: begin
        strobe_d = 1'b1;
        oid_d = nid_rd;  oqty_d = nqty_rd;  oseq_d = nseq_rd;  olast_d = lst_last;
        cur_d = nnext_rd;
        cnt_d = cnt_q + 1'b1;
        state_d = lst_last ? S_IDLE : S_LSTR;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      clr_q    <= '0;
      free_q   <= '1;
      fcnt_q   <= CW'(POOL_NODES);
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      free_q   <= free_d;
      fcnt_q   <= fcnt_d;
      strobe_q <= strobe_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;  win_q <= win_d;  li_q <= li_d;  id_q <= id_d;
    qty_q <= qty_d;  seq_q <= seq_d;  head_q <= head_d;  tail_q <= tail_d;
    sum_q <= sum_d;  cur_q <= cur_d;  nn_q <= nn_d;  np_q <= np_d;  nx_q <= nx_d;
    nq_q <= nq_d;  steps_q <= steps_d;  cnt_q <= cnt_d;  status_q <= status_d;
    sweep_q <= sweep_d;  bw_q <= bw_d;  bv_q <= bv_d;  bp_q <= bp_d;
    ostat_q <= ostat_d;  obv_q <= obv_d;  obp_q <= obp_d;  otot_q <= otot_d;
    oocc_q <= oocc_d;  oid_q <= oid_d;  oqty_q <= oqty_d;  oseq_q <= oseq_d;
    olast_q <= olast_d;
  end

  // Level records
  obse_ram #(.WIDTH($bits(obse_pkg::level_t)), .DEPTH(LEVELS)) u_level (
    .clk_i, .we_i(lv_we), .waddr_i(lv_waddr), .wdata_i(lv_wdata),
    .raddr_i(li_q), .rdata_o(lv_rdata)
  );

  // Occupancy words
  obse_ram #(.WIDTH(64), .DEPTH(OCC_WORDS)) u_occ (
    .clk_i, .we_i(oc_we), .waddr_i(oc_waddr), .wdata_i(oc_wdata),
    .raddr_i(oc_raddr), .rdata_o(oc_rdata)
  );

  // Node pool fields
  obse_ram #(.WIDTH(64), .DEPTH(POOL_NODES)) u_nid (
    .clk_i, .we_i(nid_we), .waddr_i(nw_addr), .wdata_i(id_q),
    .raddr_i(n_raddr), .rdata_o(nid_rd)
  );
  obse_ram #(.WIDTH(32), .DEPTH(POOL_NODES)) u_nqty (
    .clk_i, .we_i(nqty_we), .waddr_i(nw_addr), .wdata_i(nqty_wdata),
    .raddr_i(n_raddr), .rdata_o(nqty_rd)
  );
  obse_ram #(.WIDTH(64), .DEPTH(POOL_NODES)) u_nseq (
    .clk_i, .we_i(nseq_we), .waddr_i(nw_addr), .wdata_i(seq_q),
    .raddr_i(n_raddr), .rdata_o(nseq_rd)
  );
  obse_ram #(.WIDTH(PTRW), .DEPTH(POOL_NODES)) u_nnext (
    .clk_i, .we_i(nnext_we), .waddr_i(nnext_waddr), .wdata_i(nnext_wdata),
    .raddr_i(n_raddr), .rdata_o(nnext_rd)
  );
  obse_ram #(.WIDTH(PTRW), .DEPTH(POOL_NODES)) u_nprev (
    .clk_i, .we_i(nprev_we), .waddr_i(nprev_waddr), .wdata_i(nprev_wdata),
    .raddr_i(n_raddr), .rdata_o(nprev_rd)
  );

  assign clearing_o         = (state_q == S_CLR);
  assign strobe_o           = strobe_q;
  assign status_o           = ostat_q;
  assign best_valid_o       = obv_q;
  assign best_level_price_o = obp_q;
  assign level_total_o      = otot_q;
  assign level_occupied_o   = oocc_q;
  assign maker_id_o         = oid_q;
  assign maker_qty_o        = oqty_q;
  assign maker_seq_o        = oseq_q;
  assign last_o             = olast_q;

endmodule
`default_nettype wire

[rtl/core/order_book_side_engine.sv]
// Top level of one side of a limit order book with dense price levels.
//
//  Channel   Handshake                      Beat
//  command   start / busy                   mode, price, order id, quantity, sequence
//  result    out_strobe_o (one cycle)       status, best price, level total, maker, last
//  config    cfg_valid_i / cfg_ready_o      register index, write data
//
// The back end runs one command at a time and takes a new one only once its results are out;
// each command ends with a scan of the occupancy words from the best end (up to LEVELS/64),
// and a list emits one result per resting order of an occupied level, the last one marked.
// After reset a clearing pass over all LEVELS levels empties the level memory; busy is high.
// The result side takes every beat; a two-entry command queue absorbs back-to-back starts.
`timescale 1ns / 1ps
`default_nettype none
`include "order_book_side_engine_defines.svh"
module order_book_side_engine #(
  parameter int unsigned LEVELS     = obse_pkg::LEVELS_DEF,
  parameter int unsigned POOL_NODES = obse_pkg::POOL_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  mode_i,
  input  wire logic [31:0] price_i,
  input  wire logic [63:0] order_id_i,
  input  wire logic [31:0] quantity_i,
  input  wire logic [63:0] sequence_req_i,
  output logic             out_strobe_o,
  output logic [2:0]       status_o,
  output logic             best_valid_o,
  output logic [31:0]      best_level_price_o,
  output logic [37:0]      level_total_o,
  output logic             level_occupied_o,
  output logic [63:0]      maker_id_o,
  output logic [31:0]      maker_qty_o,
  output logic [63:0]      maker_seq_o,
  output logic             last_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  logic           base_we, high_we;
  logic [31:0]    base_q;
  logic           high_q;
  logic           q_full, q_valid, q_pop, clearing, push;
  obse_pkg::cmd_t q_head;

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  assign base_we = cfg_valid_i && (cfg_index_i == obse_pkg::CFG_BASE_PRICE);
  assign high_we = cfg_valid_i && (cfg_index_i == obse_pkg::CFG_BEST_HIGH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      high_q <= 1'b1;
    end else begin
      if (base_we) base_q <= cfg_data_i;
      if (high_we) high_q <= cfg_data_i[0];
    end
  end

  // Accept commands while the queue has room and no clearing runs
  assign busy = q_full || clearing;
  assign push = start && !busy;

  obse_front #(.LEVELS(LEVELS)) u_front (
    .clk_i, .rst_ni, .push_i(push), .mode_i, .price_i, .order_id_i, .quantity_i,
    .sequence_req_i, .base_price_i(base_q), .full_o(q_full), .valid_o(q_valid),
    .head_o(q_head), .pop_i(q_pop)
  );

  obse_back #(.LEVELS(LEVELS), .POOL_NODES(POOL_NODES)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(q_valid), .cmd_i(q_head), .cmd_pop_o(q_pop),
    .base_price_i(base_q), .best_high_i(high_q), .clearing_o(clearing),
    .strobe_o(out_strobe_o), .status_o, .best_valid_o, .best_level_price_o,
    .level_total_o, .level_occupied_o, .maker_id_o, .maker_qty_o, .maker_seq_o,
    .last_o
  );

  // Result consistency
  `OBSE_ASSERT_IMP(a_no_best_price, out_strobe_o && !best_valid_o, best_level_price_o == '0)
  `OBSE_ASSERT_IMP(a_empty_total, out_strobe_o && !level_occupied_o, level_total_o == '0)
  `OBSE_ASSERT_IMP(a_outwin_empty, out_strobe_o && status_o == obse_pkg::ST_OUT_WIN, !level_occupied_o)
  `OBSE_ASSERT_IMP(a_maker_ok, out_strobe_o && maker_seq_o != '0, status_o == obse_pkg::ST_OK)
  `OBSE_ASSERT_NXT(a_pop_idle, clearing, !q_pop)

endmodule
`default_nettype wire

[verif/order_book_side_engine_test.sv]
// Self-checking testbench for the order book side engine: driven commands, predicted results.
`timescale 1ns / 1ps
module order_book_side_engine_test;

  localparam int unsigned NUM_LEVELS    = 1024;
  localparam int unsigned NUM_NODES     = 64;
  localparam logic [2:0]  MODE_QUERY    = 3'd3;
  localparam logic [2:0]  MODE_SPARE    = 3'd5;
  localparam logic [2:0]  MODE_SPARE_MID = 3'd6;
  localparam logic [2:0]  MODE_SPARE_HI = 3'd7;
  localparam int unsigned SETTLE_CYC    = 400;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] price;
    logic [63:0] id;
    logic [31:0] qty;
    logic [63:0] seq;
  } order_cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        best_valid;
    logic [31:0] top_price;
    logic [37:0] total;
    logic        occupied;
    logic [63:0] rest_id;
    logic [31:0] maker_qty;
    logic [63:0] maker_seq;
    logic        last;
  } book_result_t;

  logic clk_i, rst_ni, busy;
  logic start = 1'b0;
  logic [2:0] mode_i = '0;
  logic [31:0] price_i = '0;
  logic [31:0] quantity_i = '0;
  logic [63:0] order_id_i = '0;
  logic [63:0] sequence_req_i = '0;
  logic out_strobe_o, best_valid_o, level_occupied_o, last_o;
  logic [2:0] status_o;
  logic [31:0] best_level_price_o, maker_qty_o;
  logic [37:0] level_total_o;
  logic [63:0] maker_id_o, maker_seq_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [7:0] cfg_index_i;
  logic [31:0] cfg_data_i;

  order_book_side_engine i_dut (.*);

  // Mirror of the book state
  logic [31:0]       bk_base;
  logic              bk_highest;
  logic [obse_pkg::PTR_W-1:0] bk_head [NUM_LEVELS];
  logic [obse_pkg::PTR_W-1:0] bk_tail [NUM_LEVELS];
  logic [obse_pkg::SUM_W-1:0] bk_sum  [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] bk_occ;
  logic [63:0]       nd_id   [NUM_NODES];
  logic [31:0]       nd_qty  [NUM_NODES];
  logic [63:0]       nd_seq  [NUM_NODES];
  logic [obse_pkg::PTR_W-1:0] nd_next [NUM_NODES];
  logic [obse_pkg::PTR_W-1:0] nd_prev [NUM_NODES];
  logic [obse_pkg::PTR_W-1:0] free_stk [NUM_NODES];
  int unsigned       free_cnt;

  order_cmd_t   pending_cmds[$];
  book_result_t expected_results[$];
  order_cmd_t   added_orders[$];
  int unsigned  fail_count = 0;
  int unsigned  gap_left = 0;
  int unsigned  taken_cnt = 0;
  int unsigned  seen_cnt = 0;
  bit           allow_gaps;

  // Clock
  always begin
    clk_i = 1'b1; #10;
    clk_i = 1'b0; #10;
  end

  function automatic void book_reset();
    bk_base = '0;
    bk_highest = 1'b1;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      bk_head[i] = obse_pkg::PTR_NIL;
      bk_tail[i] = obse_pkg::PTR_NIL;
      bk_sum[i] = '0;
    end
    bk_occ = '0;
    for (int i = 0; i < NUM_NODES; i++) free_stk[i] = obse_pkg::PTR_W'(NUM_NODES - 1 - i);
    free_cnt = NUM_NODES;
  endfunction

  function automatic logic [obse_pkg::PTR_W-1:0] find_order(int li, logic [63:0] id);
    logic [obse_pkg::PTR_W-1:0] cur;
    cur = bk_head[li];
    for (int s = 0; s < NUM_NODES && cur < NUM_NODES; s++) begin
      if (nd_id[cur] == id) return cur;
      cur = nd_next[cur];
    end
    return obse_pkg::PTR_NIL;
  endfunction

  function automatic void unlink_order(int li, logic [obse_pkg::PTR_W-1:0] n);
    logic [obse_pkg::PTR_W-1:0] p, x;
    p = nd_prev[n];
    x = nd_next[n];
    if (p < NUM_NODES) nd_next[p] = x;
    else bk_head[li] = x;
    if (x < NUM_NODES) nd_prev[x] = p;
    else bk_tail[li] = p;
    bk_sum[li] = bk_sum[li] - obse_pkg::SUM_W'(nd_qty[n]);
    if (free_cnt < NUM_NODES) begin
      free_stk[free_cnt] = n;
      free_cnt++;
    end
    if (bk_head[li] >= NUM_NODES) bk_occ[li] = 1'b0;
  endfunction

  // Apply one command to the mirror and queue the results it causes
  function automatic void apply_command(order_cmd_t c);
    logic [31:0] d, amt, bp;
    logic [obse_pkg::PTR_W-1:0] n, cur, nx;
    logic [2:0] st;
    logic win, bv;
    int li, cnt;
    book_result_t r;
    st = obse_pkg::ST_OK;
    d = c.price - bk_base;
    win = (c.price >= bk_base) && (d < NUM_LEVELS);
    li = win ? int'(d) : 0;
    if (!win) begin
      st = obse_pkg::ST_OUT_WIN;
    end else if (c.mode == obse_pkg::MODE_ADD) begin
      if (free_cnt == 0) begin
        st = obse_pkg::ST_POOL_FULL;
      end else begin
        free_cnt--;
        n = free_stk[free_cnt];
        nd_id[n] = c.id;
        nd_qty[n] = c.qty;
        nd_seq[n] = c.seq;
        nd_next[n] = obse_pkg::PTR_NIL;
        nd_prev[n] = bk_tail[li];
        if (bk_head[li] >= NUM_NODES) bk_head[li] = n;
        else if (bk_tail[li] < NUM_NODES) nd_next[bk_tail[li]] = n;
        bk_tail[li] = n;
        bk_sum[li] = bk_sum[li] + obse_pkg::SUM_W'(c.qty);
        bk_occ[li] = 1'b1;
      end
    end else if (c.mode == obse_pkg::MODE_CANCEL) begin
      n = find_order(li, c.id);
      if (n < NUM_NODES) unlink_order(li, n);
      else st = obse_pkg::ST_NOT_FOUND;
    end else if (c.mode == obse_pkg::MODE_FILL) begin
      n = find_order(li, c.id);
      if (n >= NUM_NODES) begin
        st = obse_pkg::ST_NOT_FOUND;
      end else begin
        amt = c.qty;
        if (amt > nd_qty[n]) begin
          amt = nd_qty[n];
          st = obse_pkg::ST_OVERFILL;
        end
        nd_qty[n] = nd_qty[n] - amt;
        bk_sum[li] = bk_sum[li] - obse_pkg::SUM_W'(amt);
        // sweep every emptied order off the level
        cur = bk_head[li];
        for (int s = 0; s < NUM_NODES && cur < NUM_NODES; s++) begin
          nx = nd_next[cur];
          if (nd_qty[cur] == 0) unlink_order(li, cur);
          cur = nx;
        end
      end
    end
    // best occupied level
    bv = 1'b0;
    bp = '0;
    for (int k = 0; k < NUM_LEVELS; k++) begin
      int j;
      j = bk_highest ? NUM_LEVELS - 1 - k : k;
      if (!bv && bk_occ[j]) begin
        bv = 1'b1;
        bp = bk_base + 32'(j);
      end
    end
    r = '0;
    r.status = st;
    r.best_valid = bv;
    r.top_price = bp;
    if (win && bk_occ[li]) begin
      r.total = bk_sum[li];
      r.occupied = 1'b1;
    end
    cnt = 0;
    if (c.mode == obse_pkg::MODE_LIST && r.occupied) begin
      cur = bk_head[li];
      while (cur < NUM_NODES && cnt < NUM_NODES) begin
        r.rest_id = nd_id[cur];
        r.maker_qty = nd_qty[cur];
        r.maker_seq = nd_seq[cur];
        cur = nd_next[cur];
        r.last = !(cur < NUM_NODES && cnt + 1 < NUM_NODES);
        expected_results.insert(expected_results.size(), r);
        cnt++;
      end
    end
    if (cnt == 0) begin
      r.last = 1'b1;
      expected_results.insert(expected_results.size(), r);
    end
  endfunction

  // Command driver: pick a gap after each taken beat, then present the oldest pending command
  always @(negedge clk_i) begin
    int unsigned roll;
    if (taken_cnt != seen_cnt) begin
      seen_cnt = taken_cnt;
      roll = $urandom_range(99);
      if (!allow_gaps || roll < 55) gap_left = 0;
      else if (roll < 94) gap_left = $urandom_range(4, 1);
      else gap_left = $urandom_range(60, 20);
    end
    if (rst_ni && gap_left > 0) begin
      gap_left = gap_left - 1;
      start <= 1'b0;
    end else if (rst_ni && pending_cmds.size() > 0) begin
      start <= 1'b1;
      mode_i <= pending_cmds[0].mode;
      price_i <= pending_cmds[0].price;
      order_id_i <= pending_cmds[0].id;
      quantity_i <= pending_cmds[0].qty;
      sequence_req_i <= pending_cmds[0].seq;
    end else begin
      start <= 1'b0;
    end
  end

  // Command acceptance: predict the results of the taken beat
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy && pending_cmds.size() > 0) begin
      apply_command(pending_cmds.pop_front());
      taken_cnt++;
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    book_result_t want, got;
    if (rst_ni && out_strobe_o) begin
      got = '{status_o, best_valid_o, best_level_price_o, level_total_o, level_occupied_o,
              maker_id_o, maker_qty_o, maker_seq_o, last_o};
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result beat %p", got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= 10) $display("result mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  task automatic queue_cmd(logic [2:0] mode, logic [31:0] price, logic [63:0] id,
                           logic [31:0] qty);
    order_cmd_t c;
    c = '{mode, price, id, qty, {$urandom, $urandom}};
    if (mode == obse_pkg::MODE_ADD) added_orders.insert(added_orders.size(), c);
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  task automatic drain_book();
    wait (pending_cmds.size() == 0 && expected_results.size() == 0);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == obse_pkg::CFG_BASE_PRICE) bk_base = data;
    else if (idx == obse_pkg::CFG_BEST_HIGH) bk_highest = data[0];
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Random commands, mostly aimed at a few busy levels with live order ids
  task automatic random_phase(int unsigned count, int unsigned add_pct);
    logic [2:0] mode;
    logic [31:0] price, qty;
    logic [63:0] id;
    int unsigned roll;
    order_cmd_t old;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if (roll < add_pct) mode = obse_pkg::MODE_ADD;
      else if (roll < add_pct + 20) mode = obse_pkg::MODE_FILL;
      else if (roll < add_pct + 35) mode = obse_pkg::MODE_CANCEL;
      else if (roll < add_pct + 44) mode = obse_pkg::MODE_LIST;
      else if (roll < add_pct + 50) mode = MODE_QUERY;
      else mode = 3'($urandom_range(MODE_SPARE_HI, MODE_SPARE));
      roll = $urandom_range(99);
      if (roll < 80) price = bk_base + $urandom_range(7);
      else if (roll < 88) price = bk_base + $urandom_range(NUM_LEVELS - 1);
      else if (roll < 92) price = bk_base + NUM_LEVELS - 1;
      else price = $urandom;
      id = {$urandom, $urandom};
      roll = $urandom_range(99);
      qty = (roll < 10) ? 32'd0 : (roll < 25) ? $urandom : $urandom_range(20, 1);
      if (mode != obse_pkg::MODE_ADD && added_orders.size() > 0 && $urandom_range(9) < 8) begin
        old = added_orders[$urandom_range(added_orders.size() - 1)];
        id = old.id;
        if ($urandom_range(9) < 8) price = old.price;
      end
      queue_cmd(mode, price, id, qty);
    end
  endtask

  // Time limit
  initial begin
    #20ms;
    $display("order_book_side_engine_test failed");
    $finish;
  end

  // Stimulus sequence
  initial begin
    allow_gaps = 1'b1;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    book_reset();
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: edges of the window, duplicates, overfill, sweep, unused modes
    queue_cmd(MODE_QUERY, 32'd0, '0, '0);
    queue_cmd(obse_pkg::MODE_LIST, 32'd5, '0, '0);
    queue_cmd(obse_pkg::MODE_ADD, 32'd0, '1, '1);
    queue_cmd(obse_pkg::MODE_ADD, 32'd0, 64'd0, 32'd0);
    queue_cmd(obse_pkg::MODE_ADD, 32'd1023, 64'd7, 32'd5);
    queue_cmd(obse_pkg::MODE_ADD, 32'd1023, 64'd7, 32'd9);
    queue_cmd(obse_pkg::MODE_LIST, 32'd1023, '0, '0);
    queue_cmd(obse_pkg::MODE_LIST, 32'd0, '0, '0);
    queue_cmd(obse_pkg::MODE_FILL, 32'd1023, 64'd7, 32'd2);
    queue_cmd(obse_pkg::MODE_FILL, 32'd1023, 64'd7, 32'd100);
    queue_cmd(obse_pkg::MODE_CANCEL, 32'd1023, 64'd7, '0);
    queue_cmd(obse_pkg::MODE_CANCEL, 32'd1023, 64'd7, '0);
    queue_cmd(obse_pkg::MODE_FILL, 32'd3, 64'd9, 32'd1);
    queue_cmd(obse_pkg::MODE_ADD, 32'd1024, 64'd1, 32'd1);
    queue_cmd(MODE_QUERY, '1, '0, '0);
    queue_cmd(MODE_SPARE, 32'd0, '0, '0);
    queue_cmd(MODE_SPARE_MID, 32'd0, '0, '0);
    queue_cmd(MODE_SPARE_HI, 32'd1023, '0, '0);
    queue_cmd(obse_pkg::MODE_FILL, 32'd0, '1, 32'd0);
    queue_cmd(obse_pkg::MODE_LIST, 32'd0, '0, '0);
    queue_cmd(obse_pkg::MODE_FILL, 32'd0, '1, 32'd1);
    queue_cmd(MODE_QUERY, 32'd0, '0, '0);
    drain_book();

    // Ask side, window at the top of the price range, add-heavy to fill the pool
    write_reg(obse_pkg::CFG_BEST_HIGH, 32'd0);
    write_reg(obse_pkg::CFG_BASE_PRICE, 32'hFFFF_FC00);
    random_phase(100, 60);
    drain_book();

    // Bid side, random window, no idling
    allow_gaps = 1'b0;
    write_reg(obse_pkg::CFG_BEST_HIGH, 32'd1);
    write_reg(obse_pkg::CFG_BASE_PRICE, $urandom);
    random_phase(90, 35);
    drain_book();

    // Single-level window at the maximum price
    allow_gaps = 1'b1;
    write_reg(obse_pkg::CFG_BASE_PRICE, '1);
    random_phase(40, 35);
    drain_book();

    // Back to the bottom of the range on the ask side
    write_reg(obse_pkg::CFG_BASE_PRICE, 32'd0);
    write_reg(obse_pkg::CFG_BEST_HIGH, 32'd0);
    random_phase(110, 35);
    drain_book();

    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("order_book_side_engine_test passed");
    end else begin
      $display("order_book_side_engine_test failed");
    end
    $finish;
  end

endmodule
